@@ hdl/snr_pkg.sv @@
// Shared types and constants for the sum normalize block.
// Used by the sample store, the shift-subtract divider and the top level.
package snr_pkg;

    localparam int SET_DEPTH = 64;
    localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);

    localparam int SAMPLE_W  = 32;
    localparam int RANGE_W   = 16;
    localparam int SPAN_W    = RANGE_W + 1;
    localparam int NUM_W     = SAMPLE_W + SPAN_W;
    localparam int SUM_W     = 48;
    localparam int FRAC_W    = 16;

    // dividend is |sample*span| shifted up by the fraction width
    localparam int DVD_W     = 64;
    localparam int QUO_W     = 34;
    localparam int HI_W      = DVD_W - QUO_W;
    localparam int DCNT_W    = $clog2(QUO_W + 1);

    localparam int CFG_IDX_W = 2;

    typedef logic [1:0] t_status;
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_ZERO  = 2'd1;
    localparam t_status STAT_SAT   = 2'd2;
    localparam t_status STAT_TRUNC = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT
    } t_state;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_status;

endpackage

@@ hdl/snr_store.sv @@
// Sample store: one write port and one registered read port.
// Depends on snr_pkg for depth and widths.
module snr_store (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [snr_pkg::ADDR_W-1:0]    i_wr_addr,
    input  logic [snr_pkg::SAMPLE_W-1:0]  i_wr_data,
    input  logic                          i_rd_en,
    input  logic [snr_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic [snr_pkg::SAMPLE_W-1:0]  o_rd_data
);
    import snr_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [SET_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/snr_divider.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Flags overflow up front when the quotient would not fit QUO_W bits.
// Depends on snr_pkg for widths and the status struct.
module snr_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [snr_pkg::DVD_W-1:0]   i_dividend,
    input  logic [snr_pkg::SUM_W-1:0]   i_divisor,
    output snr_pkg::t_div_status        o_status,
    output logic [snr_pkg::QUO_W-1:0]   o_quotient
);
    import snr_pkg::*;

    logic [DCNT_W-1:0] r_cnt;
    logic              r_done;
    logic              r_ovf;
    logic [SUM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_q;
    logic [SUM_W-1:0]  r_dvs;

    logic [HI_W-1:0]   dvd_hi;
    logic              start_ovf;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;

    assign dvd_hi    = i_dividend[DVD_W-1:QUO_W];
    assign start_ovf = SUM_W'(dvd_hi) >= i_divisor;
    assign trial     = {r_rem, r_q[QUO_W-1]};
    assign diff      = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ovf <= start_ovf;
                if (start_ovf) begin
                    r_done <= 1'b1;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= DCNT_W'(QUO_W);
                end
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SUM_W'(dvd_hi);
            r_q   <= i_dividend[QUO_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            // restore when the trial subtract goes negative
            if (!diff[SUM_W]) begin
                r_rem <= diff[SUM_W-1:0];
                r_q   <= {r_q[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[SUM_W-1:0];
                r_q   <= {r_q[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.ovf  = r_ovf;
    assign o_quotient    = r_q;

endmodule

@@ hdl/sum_normalize_to_range_top.sv @@
// Sum normalize: loads a set of Q16.16 samples, then emits sample*span/sum + low.
// Loading takes one sample per cycle while busy is low. Once a set closes, busy
// is high and each result takes a read, a multiply and the 34-step divider,
// which stops at once when the quotient overflows and is skipped on a zero sum.
// Results are one-cycle strobes; the receiver cannot stall. Synchronous
// active-low reset clears the set and control state and sets the range to 0..1.
module sum_normalize_to_range_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [snr_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                            i_set_end,
    output logic                            o_result_valid,
    output logic signed [snr_pkg::SAMPLE_W-1:0] o_scaled_value,
    output logic                            o_last_of_run,
    output snr_pkg::t_status                o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [snr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [snr_pkg::RANGE_W-1:0]     i_cfg_data
);
    import snr_pkg::*;

    localparam int V_W = QUO_W + 2;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_idx;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_trunc;
    logic [RANGE_W-1:0]       r_low;
    logic [RANGE_W-1:0]       r_high;
    logic signed [NUM_W-1:0]  r_num;
    logic                     r_valid;
    logic signed [SAMPLE_W-1:0] r_scaled;
    logic                     r_last;
    t_status                  r_stat;

    logic                     load;
    logic                     close;
    logic                     full;
    logic                     sum_zero;
    logic                     is_last;
    logic                     div_start;
    logic                     emit_zero;
    logic                     emit_div;
    logic                     emit;
    logic                     rd_en;

    logic [SAMPLE_W-1:0]      rd_data;
    logic signed [SPAN_W-1:0] span;
    logic [NUM_W-2:0]         num_mag;
    logic [SUM_W-1:0]         sum_mag;
    logic [DVD_W-1:0]         dividend;
    t_div_status              div_stat;
    logic [QUO_W-1:0]         quotient;
    logic                     neg;
    logic signed [QUO_W:0]    q_signed;
    logic signed [V_W-1:0]    v_sum;
    logic                     v_ovf;
    logic signed [SAMPLE_W-1:0] v_out;
    logic                     v_sat;

    snr_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (load),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    snr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (sum_mag),
        .o_status   (div_stat),
        .o_quotient (quotient)
    );

    assign full     = (r_count + 1'b1) == CNT_W'(SET_DEPTH);
    assign close    = i_set_end || full;
    assign sum_zero = (r_sum == '0);
    assign is_last  = (r_idx + 1'b1) == r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (load && close) begin
                    n_state = S_READ;
                end
            end
            S_READ:      n_state = S_MUL;
            S_MUL:       n_state = S_DIV_START;
            S_DIV_START: begin
                if (sum_zero) begin
                    n_state = is_last ? S_LOAD : S_READ;
                end else begin
                    n_state = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    n_state = is_last ? S_LOAD : S_READ;
                end
            end
            default:     n_state = S_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        load      = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        emit_zero = 1'b0;
        emit_div  = 1'b0;
        case (r_state)
            S_LOAD:      load = start;
            S_READ:      rd_en = 1'b1;
            S_MUL:       ;
            S_DIV_START: begin
                div_start = !sum_zero;
                emit_zero = sum_zero;
            end
            S_DIV_WAIT:  emit_div = div_stat.done;
            default:     ;
        endcase
    end

    assign emit = emit_zero || emit_div;
    assign busy = (r_state != S_LOAD);

    // divider operands: magnitudes, sign applied afterwards
    assign span     = $signed({r_high[RANGE_W-1], r_high}) - $signed({r_low[RANGE_W-1], r_low});
    assign num_mag  = r_num[NUM_W-1] ? (NUM_W-1)'(-r_num) : r_num[NUM_W-2:0];
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign dividend = {num_mag, FRAC_W'(0)};

    assign neg      = r_num[NUM_W-1] ^ r_sum[SUM_W-1];
    assign q_signed = neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    assign v_sum    = V_W'(q_signed) + V_W'($signed({r_low, FRAC_W'(0)}));
    assign v_ovf    = (v_sum[V_W-1:SAMPLE_W-1] != '0) && (v_sum[V_W-1:SAMPLE_W-1] != '1);

    always_comb begin
        v_sat = 1'b0;
        v_out = v_sum[SAMPLE_W-1:0];
        if (div_stat.ovf) begin
            v_sat = 1'b1;
            v_out = neg ? {1'b1, (SAMPLE_W-1)'(0)} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (v_ovf) begin
            v_sat = 1'b1;
            v_out = v_sum[V_W-1] ? {1'b1, (SAMPLE_W-1)'(0)} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            r_trunc <= 1'b0;
            r_low   <= '0;
            r_high  <= RANGE_W'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= emit;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RANGE_LOW:  r_low  <= i_cfg_data;
                    CFG_RANGE_HIGH: r_high <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (load) begin
                r_sum   <= r_sum + SUM_W'(i_sample);
                r_count <= r_count + 1'b1;
                r_idx   <= '0;
                r_trunc <= full && !i_set_end;
            end
            if (emit) begin
                if (is_last) begin
                    // drop the finished set
                    r_count <= '0;
                    r_sum   <= '0;
                    r_trunc <= 1'b0;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_num <= $signed(rd_data) * span;
        end
        if (emit) begin
            r_last <= is_last;
            if (emit_zero) begin
                r_scaled <= '0;
                r_stat   <= STAT_ZERO;
            end else begin
                r_scaled <= v_out;
                r_stat   <= v_sat ? STAT_SAT : (r_trunc ? STAT_TRUNC : STAT_OK);
            end
        end
    end

    // hold range writes off while a set is being emitted
    assign o_cfg_ready    = !busy;
    assign o_result_valid = r_valid;
    assign o_scaled_value = r_scaled;
    assign o_last_of_run  = r_last;
    assign o_status       = r_stat;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SET_DEPTH))
        else $error("stored count beyond set depth");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without emission");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_of_run) |-> (r_count == '0 && !busy))
        else $error("set not cleared after its last result");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == STAT_ZERO) |-> (o_scaled_value == '0))
        else $error("zero-sum result carries a value");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == STAT_SAT) |->
        (o_scaled_value == {1'b1, (SAMPLE_W-1)'(0)} ||
         o_scaled_value == {1'b0, {(SAMPLE_W-1){1'b1}}}))
        else $error("saturated result not at a limit");

endmodule

@@ tb/sum_normalize_to_range_top_test.sv @@
// Self-checking bench for sum_normalize_to_range_top: drives sample sets and range writes
// and checks every scaled result against an in-bench predictor of the normalization.
// Depends on snr_pkg and the sum_normalize_to_range_top RTL.
`timescale 1ns / 1ps

module sum_normalize_to_range_top_test;
    import snr_pkg::*;

    localparam int     RAND_PER_PHASE = 14;
    localparam int     PHASE_COUNT    = 8;
    localparam int     DRAIN_CYCLES   = 60;
    localparam int     END_CYCLES     = 200;
    localparam int     QUIET_FIRST    = 120;
    localparam int     QUIET_LAST     = 180;
    localparam longint QUOT_LIMIT     = 64'sd8589934592;
    localparam longint VALUE_MAX      = 64'sd2147483647;
    localparam longint VALUE_MIN      = -64'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int SET_WIDE     = 0;
    localparam int SET_NARROW   = 1;
    localparam int SET_ZERO_SUM = 2;
    localparam int SET_FULL     = 3;
    localparam int SET_OVERRUN  = 4;

    localparam int ONE_Q16 = 32'h0001_0000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
        t_status                    status;
    } t_norm_result;

    class t_norm_checker;
        int           open_set[$];
        longint       open_sum;
        shortint      range_low;
        shortint      range_high;
        t_norm_result scaled_due[$];
        int           errors;

        function new();
            open_sum   = 0;
            range_low  = 0;
            range_high = 1;
            errors     = 0;
        endfunction

        function int open_count();
            return open_set.size();
        endfunction

        function int outstanding();
            return scaled_due.size();
        endfunction

        function void set_range(logic [CFG_IDX_W-1:0] idx, logic [RANGE_W-1:0] val);
            if (idx == CFG_RANGE_LOW) begin
                range_low = shortint'(val);
            end else if (idx == CFG_RANGE_HIGH) begin
                range_high = shortint'(val);
            end
        endfunction

        // Emit the whole open set as expected results, then empty it.
        function void close_and_scale(bit truncated);
            longint       low, span, num, q, r, frac, v;
            bit           sat;
            t_norm_result res;
            low  = longint'(range_low);
            span = longint'(range_high) - low;
            foreach (open_set[i]) begin
                res.last = (i == open_set.size() - 1);
                if (open_sum == 0) begin
                    res.value  = '0;
                    res.status = STAT_ZERO;
                end else begin
                    num  = longint'(open_set[i]) * span;
                    q    = num / open_sum;
                    r    = num - q * open_sum;
                    frac = (r * 65536) / open_sum;
                    // clamp the integer part before scaling so the sum cannot wrap
                    if (q > QUOT_LIMIT) q = QUOT_LIMIT;
                    if (q < -QUOT_LIMIT) q = -QUOT_LIMIT;
                    v   = q * 65536 + frac + low * 65536;
                    sat = 1'b0;
                    if (v > VALUE_MAX) begin
                        v   = VALUE_MAX;
                        sat = 1'b1;
                    end
                    if (v < VALUE_MIN) begin
                        v   = VALUE_MIN;
                        sat = 1'b1;
                    end
                    res.value = v[SAMPLE_W-1:0];
                    if (sat) res.status = STAT_SAT;
                    else if (truncated) res.status = STAT_TRUNC;
                    else res.status = STAT_OK;
                end
                scaled_due.push_back(res);
            end
            open_set.delete();
            open_sum = 0;
        endfunction

        function void note_sample(int sample, bit set_end);
            open_set.push_back(sample);
            open_sum += longint'(sample);
            if (set_end) close_and_scale(1'b0);
            else if (open_set.size() >= SET_DEPTH) close_and_scale(1'b1);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        task check_result(logic [SAMPLE_W-1:0] value, logic last, logic [1:0] status);
            t_norm_result due;
            if (scaled_due.size() == 0) begin
                report_mismatch($sformatf("result %h arrived with no request pending", value));
                return;
            end
            due = scaled_due.pop_front();
            if (value !== due.value)
                report_mismatch($sformatf("scaled_value %h, predicted %h", value, due.value));
            if (last !== due.last)
                report_mismatch($sformatf("last_of_run %b, predicted %b", last, due.last));
            if (status !== due.status)
                report_mismatch($sformatf("status %0d, predicted %0d", status, due.status));
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        i_set_end;
    logic                        o_result_valid;
    logic signed [SAMPLE_W-1:0]  o_scaled_value;
    logic                        o_last_of_run;
    t_status                     o_status;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [RANGE_W-1:0]          i_cfg_data;

    t_norm_checker norm_chk;
    int            items_sent = 0;

    sum_normalize_to_range_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample       (i_sample),
        .i_set_end      (i_set_end),
        .o_result_valid (o_result_valid),
        .o_scaled_value (o_scaled_value),
        .o_last_of_run  (o_last_of_run),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1)
            norm_chk.check_result(o_scaled_value, o_last_of_run, o_status);
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_sample(bit narrow);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return 32'h7FFF_FFFF;
        if (roll < 6) return 32'h8000_0000;
        if (roll < 8) return 0;
        if (roll < 10) return -1;
        if (narrow) return int'($urandom_range(0, 1048576)) - 524288;
        return $urandom;
    endfunction

    task automatic send_sample(int sample, bit set_end);
        start     <= 1'b1;
        i_sample  <= sample;
        i_set_end <= set_end;
        do @(posedge i_clk); while (busy !== 1'b0);
        norm_chk.note_sample(sample, set_end);
        items_sent++;
        // idle now and then, except through one long stretch
        if ((items_sent < QUIET_FIRST || items_sent >= QUIET_LAST)
                && $urandom_range(99) < 20) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_pair(int first, int second);
        send_sample(first, 1'b0);
        send_sample(second, 1'b1);
    endtask

    task automatic send_set();
        int kind, len, roll, acc, s;
        roll = $urandom_range(99);
        if (roll < 38) kind = SET_WIDE;
        else if (roll < 76) kind = SET_NARROW;
        else if (roll < 90) kind = SET_ZERO_SUM;
        else if (roll < 95) kind = SET_FULL;
        else kind = SET_OVERRUN;
        case (kind)
            SET_ZERO_SUM: len = $urandom_range(2, 6);
            SET_FULL, SET_OVERRUN: len = SET_DEPTH;
            default: len = $urandom_range(1, 8);
        endcase
        acc = 0;
        for (int k = 0; k < len; k++) begin
            if (kind == SET_ZERO_SUM && k == len - 1) s = -acc;
            else if (kind == SET_ZERO_SUM) s = int'($urandom_range(0, 1048576)) - 524288;
            else s = pick_sample(kind == SET_NARROW);
            acc += s;
            send_sample(s, (k == len - 1) && kind != SET_OVERRUN);
        end
    endtask

    // Close any open set, then hold until every result is out and the block is idle.
    task automatic settle();
        if (norm_chk.open_count() != 0) send_sample(pick_sample(1'b1), 1'b1);
        start <= 1'b0;
        while (norm_chk.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_ranges(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi, bit poke);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [RANGE_W-1:0]   val [4];
        int                   n;
        idx[0] = CFG_RANGE_LOW;
        val[0] = lo;
        idx[1] = CFG_RANGE_HIGH;
        val[1] = hi;
        n = 2;
        // unused indexes go last so a stray write would show in the next set
        if (poke) begin
            idx[2] = CFG_SPARE_A;
            val[2] = RANGE_W'($urandom);
            idx[3] = CFG_SPARE_B;
            val[3] = RANGE_W'($urandom);
            n = 4;
        end
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            norm_chk.set_range(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [RANGE_W-1:0] lo, hi;
        int                 phase_start;
        norm_chk    = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_sample    <= '0;
        i_set_end   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_RANGE_LOW;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset range 0..1: halves, single extremes, zero sums
        send_pair(ONE_Q16, ONE_Q16);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(-1, 1'b1);
        send_sample(0, 1'b1);
        send_pair(5 * ONE_Q16, -5 * ONE_Q16);
        settle();

        // widest span: a sum of one lsb saturates both ways; extreme samples follow
        program_ranges(16'h8000, 16'h7FFF, 1'b0);
        send_pair(ONE_Q16, 32'hFFFF_0001);
        send_pair(32'h7FFF_FFFF, 1);
        send_pair(32'h8000_0000, -1);
        settle();

        // reversed range, no swap
        program_ranges(16'd100, -16'sd100, 1'b1);
        send_pair(2 * ONE_Q16, 3 * ONE_Q16);
        send_pair(-7 * ONE_Q16, ONE_Q16);
        settle();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin lo = 16'h8000; hi = 16'h7FFF; end
                1: begin lo = 16'h7FFF; hi = 16'h8000; end
                2: begin lo = 16'h0000; hi = 16'h0000; end
                3: begin lo = 16'h8000; hi = 16'h8000; end
                4: begin lo = 16'h7FFF; hi = 16'h7FFF; end
                5: begin lo = 16'h0000; hi = 16'h0001; end
                default: begin lo = RANGE_W'($urandom); hi = RANGE_W'($urandom); end
            endcase
            program_ranges(lo, hi, (phase % 3) == 0);
            phase_start = items_sent;
            while (items_sent - phase_start < RAND_PER_PHASE) send_set();
            settle();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (norm_chk.errors == 0 && norm_chk.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
